// ----- rtl/rgb2yuv_pkg.sv -----
package rgb2yuv_pkg;

    // Field widths
    localparam int PIX_W     = 8;                 // one color component
    localparam int S_DATA_W  = 3 * PIX_W;         // red, green, blue
    localparam int M_DATA_W  = 2 * PIX_W;         // luma, chroma
    localparam int M_USER_W  = 2;                 // chroma_valid, chroma_plane
    localparam int CFG_W     = 13;                // frame size registers
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Reset sizes
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Luma path: unsigned sum, at most 220 * 255 + 128
    localparam int LSUM_W = 16;
    localparam logic [LSUM_W-1:0] Y_R       = 16'd66;
    localparam logic [LSUM_W-1:0] Y_G       = 16'd129;
    localparam logic [LSUM_W-1:0] Y_B       = 16'd25;
    localparam logic [LSUM_W-1:0] ROUND     = 16'd128;
    localparam logic [PIX_W-1:0]  Y_OFFSET  = 8'd16;

    // Chroma path: signed sum in -28432..28688
    localparam int CSUM_W = 19;
    localparam logic signed [CSUM_W-1:0] CB_R   = -19'sd38;
    localparam logic signed [CSUM_W-1:0] CB_G   = -19'sd74;
    localparam logic signed [CSUM_W-1:0] CB_B   = 19'sd112;
    localparam logic signed [CSUM_W-1:0] CR_R   = 19'sd112;
    localparam logic signed [CSUM_W-1:0] CR_G   = -19'sd94;
    localparam logic signed [CSUM_W-1:0] CR_B   = -19'sd18;
    localparam logic signed [CSUM_W-1:0] C_ROUND = 19'sd128;
    // 128 << 8: adds the chroma offset of 128 before the shift
    localparam logic signed [CSUM_W-1:0] C_BIAS  = 19'sd32768;

    // Chroma plane codes
    localparam logic PLANE_CB = 1'b0;
    localparam logic PLANE_CR = 1'b1;

    // Per-pixel chroma control
    typedef struct packed {
        logic en;       // even column: emit a chroma sample
        logic plane;    // PLANE_CB on even rows, PLANE_CR on odd rows
    } chroma_ctl_t;

endpackage

// ----- rtl/rgb_to_yuv420_converter.sv -----
// RGB to YUV 4:2:0 converter, BT.601 limited range. Pixels arrive in raster
// order, one item per clock while the output is not stalled, and every pixel
// gives one result item: an input register holds the pixel and its position
// flags, and the color matrix (constant multiplies and adds) feeds the result
// register. The block sustains one item per cycle unless m_tready stalls it;
// the frame counters step at input acceptance, so back-to-back pixels are taken
// without a gap. Luma is given for every pixel; even columns also carry Cb on
// even rows and Cr on odd rows (tuser[0] marks a chroma sample, tuser[1] gives
// the plane). tlast marks the last pixel of a frame. A frame size of 0 acts as
// 1, and sizes above MAX_WIDTH / MAX_HEIGHT act as those limits. The user must
// write size registers only while no pixel is in flight; the block does not check.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rgb2yuv_pkg::S_DATA_W-1:0]  s_tdata,   // red, green, blue
    // Result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rgb2yuv_pkg::M_DATA_W-1:0]  m_tdata,   // luma, chroma
    output logic [rgb2yuv_pkg::M_USER_W-1:0]  m_tuser,   // chroma_valid, chroma_plane
    output logic                              m_tlast,   // frame_end
    // Register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_data
);
    import rgb2yuv_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    // Configuration
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;

    // Frame position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Input stage
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    chroma_ctl_t       s1_ctl_reg;
    logic              s1_last_reg;

    // Result stage
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;
    logic                m_last_reg;

    logic [WCMP_W-1:0] eff_width, col_inc;
    logic [HCMP_W-1:0] eff_height, row_inc;
    logic              last_col, last_row, frame_end;
    logic              s_accept, out_load, s1_move;
    logic [PIX_W-1:0]  luma, chroma;

    // Handshake: the result register frees the input stage
    assign out_load = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_load;
    assign s_tready = !s1_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, clipped to the maximum
    always_comb begin
        if (frame_width_reg == '0) begin
            eff_width = WCMP_W'(1);
        end else if (WCMP_W'(frame_width_reg) > WCMP_W'(MAX_WIDTH)) begin
            eff_width = WCMP_W'(MAX_WIDTH);
        end else begin
            eff_width = WCMP_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_height = HCMP_W'(1);
        end else if (HCMP_W'(frame_height_reg) > HCMP_W'(MAX_HEIGHT)) begin
            eff_height = HCMP_W'(MAX_HEIGHT);
        end else begin
            eff_height = HCMP_W'(frame_height_reg);
        end
    end

    // Position flags and counter step; >= also catches a shrunk frame
    always_comb begin
        col_inc   = WCMP_W'(col_reg) + WCMP_W'(1);
        row_inc   = HCMP_W'(row_reg) + HCMP_W'(1);
        last_col  = col_inc >= eff_width;
        last_row  = row_inc >= eff_height;
        frame_end = last_col && last_row;
        col_next  = col_reg;
        row_next  = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : ROW_W'(row_inc);
        end else begin
            col_next = COL_W'(col_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_red_reg       <= s_tdata[0*PIX_W +: PIX_W];
            s1_green_reg     <= s_tdata[1*PIX_W +: PIX_W];
            s1_blue_reg      <= s_tdata[2*PIX_W +: PIX_W];
            s1_ctl_reg.en    <= !col_reg[0];
            s1_ctl_reg.plane <= row_reg[0] ? PLANE_CR : PLANE_CB;
            s1_last_reg      <= frame_end;
        end
    end

    // Color matrix
    rgb2yuv_csc u_csc (
        .red    (s1_red_reg),
        .green  (s1_green_reg),
        .blue   (s1_blue_reg),
        .ctl    (s1_ctl_reg),
        .luma   (luma),
        .chroma (chroma)
    );

    // Result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Result stage payload
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg <= {chroma, luma};
            m_user_reg <= {s1_ctl_reg.plane, s1_ctl_reg.en};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // No chroma value without a chroma sample
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[M_DATA_W-1 -: PIX_W] == '0)
        else $error("chroma nonzero on a luma-only item");

    // Luma stays in limited range
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PIX_W-1:0] >= 8'd16) && (m_tdata[PIX_W-1:0] <= 8'd235))
        else $error("luma out of limited range");

    // Counters wrap after the last pixel of a frame
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("frame counters did not wrap");

    // A stalled result holds while the input stage is full
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s1_valid_reg |=> s1_valid_reg && m_tvalid)
        else $error("input stage lost an item under stall");

endmodule

// ----- rtl/rgb2yuv_csc.sv -----
module rgb2yuv_csc (
    input  logic [rgb2yuv_pkg::PIX_W-1:0] red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] blue,
    input  rgb2yuv_pkg::chroma_ctl_t      ctl,
    output logic [rgb2yuv_pkg::PIX_W-1:0] luma,
    output logic [rgb2yuv_pkg::PIX_W-1:0] chroma
);
    import rgb2yuv_pkg::*;

    logic [LSUM_W-1:0]        r_u, g_u, b_u;
    logic [LSUM_W-1:0]        y_sum;
    logic signed [CSUM_W-1:0] r_s, g_s, b_s;
    logic signed [CSUM_W-1:0] cb_sum, cr_sum, c_sel, c_biased;

    // Zero-extended components
    assign r_u = LSUM_W'(red);
    assign g_u = LSUM_W'(green);
    assign b_u = LSUM_W'(blue);
    assign r_s = $signed(CSUM_W'(red));
    assign g_s = $signed(CSUM_W'(green));
    assign b_s = $signed(CSUM_W'(blue));

    // Luma: round, shift by 8, add black level
    assign y_sum = Y_R * r_u + Y_G * g_u + Y_B * b_u + ROUND;
    assign luma  = y_sum[LSUM_W-1 -: PIX_W] + Y_OFFSET;

    // Chroma: both planes, pick by row parity
    assign cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s + C_ROUND;
    assign cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s + C_ROUND;
    assign c_sel  = (ctl.plane == PLANE_CR) ? cr_sum : cb_sum;

    // Bias makes the sum non-negative, so the floor shift is a bit-select
    assign c_biased = c_sel + C_BIAS;
    assign chroma   = ctl.en ? c_biased[15:8] : '0;

endmodule
